/* rtl/core/rarmt_pkg.sv */
// ============================================================================
// rarmt_pkg: shared types and constants for the range add / range min tree
// Word types of the command and result channels, the node word kept in the
// tree memory, operation codes and the signed minimum helper.
// ============================================================================
package rarmt_pkg;

  localparam int SIZE_DEF = 1024;
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [31:0] LARGEST = 32'h7FFF_FFFF;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         first_index;
    logic [9:0]         last_index;
    logic signed [31:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic               range_error;
  } out_word_t;

  typedef struct packed {
    logic [31:0] nm;
    logic [31:0] pa;
  } node_word_t;

  function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

endpackage

/* rtl/core/rarmt_node_mem.sv */
// ============================================================================
// rarmt_node_mem: tree node memory
// One write port and one read port with registered read data. Each word holds
// a node's subtree minimum and its pending addition.
// ============================================================================
module rarmt_node_mem #(
  parameter int DEPTH = 4 * rarmt_pkg::SIZE_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  rarmt_pkg::node_word_t  wr_data,
  input  logic [AW-1:0]          rd_addr,
  output rarmt_pkg::node_word_t  rd_data
);

  rarmt_pkg::node_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/range_add_range_min_tree.sv */
// ============================================================================
// range_add_range_min_tree: segment tree with pending additions
// Loads single elements, adds a value over an index range and returns the
// minimum over an index range, walking the tree with a frame stack.
// ============================================================================
//
//   channel   ports                          direction  timing
//   command   start, busy, in_data           in         taken when start && !busy
//   result    out_valid, out_data            out        one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_data in         taken when valid && ready
//
// A rejected or unused command answers in the cycle after it is taken. A walk
// pops a node that a query skips and settles any other node, handing its
// pending addition to its children; an add or a load closes a node it splits
// by taking the minimum of its children. After reset a clearing pass keeps
// busy high. The result strobe cannot be held off; busy covers the whole walk.
// ============================================================================
module range_add_range_min_tree #(
  parameter int SIZE = rarmt_pkg::SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rarmt_pkg::in_word_t               in_data,
  output logic                              out_valid,
  output rarmt_pkg::out_word_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rarmt_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int MD = 4 * SIZE;
  localparam int NW = $clog2(MD);
  localparam int LW = ($clog2(SIZE) > 11) ? $clog2(SIZE) : 11;
  localparam int CW = LW + 1;
  localparam int STK = $clog2(SIZE) + 1;
  localparam int SPW = $clog2(STK + 1);
  localparam int IXW = $clog2(STK);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_VISIT  = 10'b00_0000_0100,
    S_ST_RD  = 10'b00_0000_1000,
    S_ST_UPD = 10'b00_0001_0000,
    S_ST_C1  = 10'b00_0010_0000,
    S_ST_C2  = 10'b00_0100_0000,
    S_RC_RD1 = 10'b00_1000_0000,
    S_RC_RD2 = 10'b01_0000_0000,
    S_RC_WR  = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    F_ENTER, F_SETTLED, F_MID, F_SIBDONE, F_LWAIT, F_RIGHTDONE
  } stage_t;

  state_t state_r, state_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [SPW-1:0] sp_r, sp_nxt, sp_dec;
  logic [rarmt_pkg::COUNT_W-1:0] count_r;

  logic [NW-1:0] stk_node_r [STK];
  logic [LW-1:0] stk_lo_r [STK];
  logic [LW-1:0] stk_hi_r [STK];
  stage_t stk_stage_r [STK];

  logic [1:0] func_r, func_nxt;
  logic [LW-1:0] l_r, l_nxt, r_r, r_nxt;
  logic [31:0] v_r, v_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] set_nm_r, set_nm_nxt;
  logic [31:0] amt_r, amt_nxt;
  logic [31:0] m1_r, m1_nxt;
  logic [NW-1:0] st_node_r, st_node_nxt;
  logic st_leaf_r, st_leaf_nxt, st_load_r, st_load_nxt;
  logic [31:0] st_extra_r, st_extra_nxt;
  logic out_valid_r, out_valid_nxt;
  rarmt_pkg::out_word_t out_data_r, out_data_nxt;

  logic mem_we;
  logic [NW-1:0] mem_waddr, mem_raddr;
  rarmt_pkg::node_word_t mem_wdata, mem_rdata;

  logic [IXW-1:0] top_ix, push_ix;
  logic [NW-1:0] t_node, t_c1, t_c2, s_c1, s_c2;
  logic [LW-1:0] t_lo, t_hi, t_mid;
  stage_t t_stage;
  logic disj, cov, leaf;

  logic stage_we, push_en, do_pop;
  stage_t stage_val;
  logic [NW-1:0] push_node;
  logic [LW-1:0] push_lo, push_hi;

  logic [CW-1:0] cnt_ext, n_act;
  logic [LW-1:0] in_l, in_r;
  logic in_err;
  logic [31:0] amt, new_nm;

  rarmt_node_mem #(.DEPTH(MD)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign sp_dec = sp_r - SPW'(1);
  assign top_ix = sp_dec[IXW-1:0];
  assign push_ix = sp_r[IXW-1:0];
  assign t_node = stk_node_r[top_ix];
  assign t_lo = stk_lo_r[top_ix];
  assign t_hi = stk_hi_r[top_ix];
  assign t_stage = stk_stage_r[top_ix];
  assign t_mid = t_lo + ((t_hi - t_lo) >> 1);
  assign t_c1 = (t_node << 1) + NW'(1);
  assign t_c2 = (t_node << 1) + NW'(2);
  assign s_c1 = (st_node_r << 1) + NW'(1);
  assign s_c2 = (st_node_r << 1) + NW'(2);
  assign disj = (t_lo > r_r) || (t_hi < l_r);
  assign cov = (l_r <= t_lo) && (t_hi <= r_r);
  assign leaf = (t_lo == t_hi);

  assign cnt_ext = CW'(count_r);
  assign n_act = (cnt_ext == '0) ? CW'(1) : ((cnt_ext > CW'(SIZE)) ? CW'(SIZE) : cnt_ext);
  assign in_l = LW'(in_data.first_index);
  assign in_r = LW'(in_data.last_index);
  assign in_err = (in_data.func == rarmt_pkg::FUNC_LOAD) ? (CW'(in_l) >= n_act)
                : ((in_l > in_r) || (CW'(in_r) >= n_act));

  assign amt = mem_rdata.pa + st_extra_r;
  assign new_nm = st_load_r ? v_r : (mem_rdata.nm + amt);

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    sp_nxt = sp_r;
    func_nxt = func_r;
    l_nxt = l_r;
    r_nxt = r_r;
    v_nxt = v_r;
    acc_nxt = acc_r;
    set_nm_nxt = set_nm_r;
    amt_nxt = amt_r;
    m1_nxt = m1_r;
    st_node_nxt = st_node_r;
    st_leaf_nxt = st_leaf_r;
    st_load_nxt = st_load_r;
    st_extra_nxt = st_extra_r;
    out_valid_nxt = 1'b0;
    out_data_nxt = out_data_r;
    mem_we = 1'b0;
    mem_waddr = st_node_r;
    mem_wdata = '0;
    mem_raddr = st_node_r;
    stage_we = 1'b0;
    stage_val = t_stage;
    push_en = 1'b0;
    push_node = t_c1;
    push_lo = t_lo;
    push_hi = t_mid;
    do_pop = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == NW'(MD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          func_nxt = in_data.func;
          l_nxt = in_l;
          r_nxt = in_r;
          v_nxt = in_data.operand_value;
          if (in_data.func != rarmt_pkg::FUNC_LOAD && in_data.func != rarmt_pkg::FUNC_ADD
              && in_data.func != rarmt_pkg::FUNC_QUERY) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = '0;
          end else if (in_err) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.min_value = '0;
            out_data_nxt.range_error = 1'b1;
          end else begin
            push_en = 1'b1;
            push_node = '0;
            push_lo = '0;
            push_hi = LW'(n_act - CW'(1));
            sp_nxt = sp_r + SPW'(1);
            acc_nxt = rarmt_pkg::LARGEST;
            state_nxt = S_VISIT;
          end
        end
      end
      S_VISIT: begin
        case (t_stage)
          F_ENTER: begin
            if (func_r == rarmt_pkg::FUNC_QUERY && disj) begin
              do_pop = 1'b1;
            end else begin
              st_node_nxt = t_node;
              st_leaf_nxt = leaf;
              st_extra_nxt = (func_r == rarmt_pkg::FUNC_ADD && cov) ? v_r : '0;
              st_load_nxt = (func_r == rarmt_pkg::FUNC_LOAD) && leaf;
              stage_we = 1'b1;
              stage_val = F_SETTLED;
              state_nxt = S_ST_RD;
            end
          end
          F_SETTLED: begin
            if (func_r == rarmt_pkg::FUNC_QUERY) begin
              if (cov) begin
                acc_nxt = rarmt_pkg::smin(acc_r, set_nm_r);
                do_pop = 1'b1;
              end else begin
                stage_we = 1'b1;
                stage_val = F_MID;
                push_en = 1'b1;
              end
            end else if (func_r == rarmt_pkg::FUNC_ADD) begin
              if (disj || cov) begin
                do_pop = 1'b1;
              end else begin
                stage_we = 1'b1;
                stage_val = F_MID;
                push_en = 1'b1;
              end
            end else begin
              if (leaf) begin
                do_pop = 1'b1;
              end else if (l_r <= t_mid) begin
                stage_we = 1'b1;
                stage_val = F_LWAIT;
                push_en = 1'b1;
              end else begin
                st_node_nxt = t_c1;
                st_leaf_nxt = (t_lo == t_mid);
                st_extra_nxt = '0;
                st_load_nxt = 1'b0;
                stage_we = 1'b1;
                stage_val = F_SIBDONE;
                state_nxt = S_ST_RD;
              end
            end
          end
          F_MID, F_SIBDONE: begin
            stage_we = 1'b1;
            stage_val = F_RIGHTDONE;
            push_en = 1'b1;
            push_node = t_c2;
            push_lo = t_mid + LW'(1);
            push_hi = t_hi;
          end
          F_LWAIT: begin
            st_node_nxt = t_c2;
            st_leaf_nxt = ((t_mid + LW'(1)) == t_hi);
            st_extra_nxt = '0;
            st_load_nxt = 1'b0;
            stage_we = 1'b1;
            stage_val = F_RIGHTDONE;
            state_nxt = S_ST_RD;
          end
          F_RIGHTDONE: begin
            if (func_r == rarmt_pkg::FUNC_QUERY) begin
              do_pop = 1'b1;
            end else begin
              state_nxt = S_RC_RD1;
            end
          end
          default: begin
            do_pop = 1'b1;
          end
        endcase
        if (push_en) begin
          sp_nxt = sp_r + SPW'(1);
        end
      end
      S_ST_RD: begin
        mem_raddr = st_node_r;
        state_nxt = S_ST_UPD;
      end
      S_ST_UPD: begin
        mem_we = 1'b1;
        mem_waddr = st_node_r;
        mem_wdata.nm = new_nm;
        mem_wdata.pa = '0;
        set_nm_nxt = new_nm;
        if (!st_leaf_r && amt != '0) begin
          amt_nxt = amt;
          mem_raddr = s_c1;
          state_nxt = S_ST_C1;
        end else begin
          state_nxt = S_VISIT;
        end
      end
      S_ST_C1: begin
        mem_we = 1'b1;
        mem_waddr = s_c1;
        mem_wdata.nm = mem_rdata.nm;
        mem_wdata.pa = mem_rdata.pa + amt_r;
        mem_raddr = s_c2;
        state_nxt = S_ST_C2;
      end
      S_ST_C2: begin
        mem_we = 1'b1;
        mem_waddr = s_c2;
        mem_wdata.nm = mem_rdata.nm;
        mem_wdata.pa = mem_rdata.pa + amt_r;
        state_nxt = S_VISIT;
      end
      S_RC_RD1: begin
        mem_raddr = t_c1;
        state_nxt = S_RC_RD2;
      end
      S_RC_RD2: begin
        mem_raddr = t_c2;
        m1_nxt = mem_rdata.nm;
        state_nxt = S_RC_WR;
      end
      S_RC_WR: begin
        mem_we = 1'b1;
        mem_waddr = t_node;
        mem_wdata.nm = rarmt_pkg::smin(m1_r, mem_rdata.nm);
        mem_wdata.pa = '0;
        do_pop = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_pop) begin
      if (sp_r == SPW'(1)) begin
        sp_nxt = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt.min_value = (func_r == rarmt_pkg::FUNC_QUERY) ? acc_nxt : '0;
        out_data_nxt.range_error = 1'b0;
        state_nxt = S_IDLE;
      end else begin
        sp_nxt = sp_dec;
        state_nxt = S_VISIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      sp_r <= '0;
      out_valid_r <= 1'b0;
      count_r <= rarmt_pkg::COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      sp_r <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    l_r <= l_nxt;
    r_r <= r_nxt;
    v_r <= v_nxt;
    acc_r <= acc_nxt;
    set_nm_r <= set_nm_nxt;
    amt_r <= amt_nxt;
    m1_r <= m1_nxt;
    st_node_r <= st_node_nxt;
    st_leaf_r <= st_leaf_nxt;
    st_load_r <= st_load_nxt;
    st_extra_r <= st_extra_nxt;
    out_data_r <= out_data_nxt;
    if (stage_we) begin
      stk_stage_r[top_ix] <= stage_val;
    end
    if (push_en) begin
      stk_node_r[push_ix] <= push_node;
      stk_lo_r[push_ix] <= push_lo;
      stk_hi_r[push_ix] <= push_hi;
      stk_stage_r[push_ix] <= F_ENTER;
    end
  end

  // The frame stack is empty whenever the block waits for a command.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (sp_r == '0))
    else $error("frame stack not empty while idle");

  // The walk never goes deeper than the tree height.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STK))
    else $error("frame stack overflow");

  // A rejected command carries a zero minimum.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |-> (out_data.min_value == '0))
    else $error("error result with nonzero minimum");

  // A child update always follows the node update of the same settle step.
  a_settle_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ST_C1) |-> ($past(state_r) == S_ST_UPD))
    else $error("child update out of order");

endmodule

/* bench/tb_top.sv */
// ============================================================================
// tb_top: testbench for the range add / range minimum segment tree
// Commands are queued by a sequencer and driven with random idle bursts. Each
// accepted word is run through a behavioral tree with pending additions, and
// every result strobe is checked against the oldest predicted word. The
// element count is rewritten between phases, its extremes included.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

  localparam int NODES = 4096;
  localparam int LIMIT = 5000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rarmt_pkg::in_word_t in_data;
  logic out_valid;
  rarmt_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [rarmt_pkg::COUNT_W-1:0] cfg_data;

  range_add_range_min_tree uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic [31:0] tree_min [NODES];
  logic [31:0] tree_add [NODES];
  logic [rarmt_pkg::COUNT_W-1:0] count_reg;

  rarmt_pkg::in_word_t cmd_q[$];
  rarmt_pkg::out_word_t answer_q[$];
  int errors;
  int cycles;
  int n_words;
  int n_queries;
  int n_rejects;
  int idle_left;
  bit calm;
  bit took;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int used_count();
    if (count_reg == 0) return 1;
    if (count_reg > rarmt_pkg::SIZE_DEF) return rarmt_pkg::SIZE_DEF;
    return int'(count_reg);
  endfunction

  function automatic logic [31:0] node_min(int node);
    return (node < NODES) ? tree_min[node] : rarmt_pkg::LARGEST;
  endfunction

  function automatic void pass_down(int node, int lo, int hi);
    logic [31:0] p;
    if (node >= NODES) return;
    p = tree_add[node];
    if (p != 0) begin
      tree_min[node] = tree_min[node] + p;
      if (lo != hi) begin
        if (2 * node + 1 < NODES) tree_add[2 * node + 1] = tree_add[2 * node + 1] + p;
        if (2 * node + 2 < NODES) tree_add[2 * node + 2] = tree_add[2 * node + 2] + p;
      end
      tree_add[node] = 0;
    end
  endfunction

  function automatic void refresh(int node);
    if (node < NODES) begin
      tree_min[node] = rarmt_pkg::smin(node_min(2 * node + 1), node_min(2 * node + 2));
    end
  endfunction

  function automatic void walk_add(int node, int lo, int hi, int l, int r,
                                   logic [31:0] v);
    int mid;
    if (node >= NODES) return;
    pass_down(node, lo, hi);
    if (l > hi || lo > r) return;
    if (l <= lo && hi <= r) begin
      tree_min[node] = tree_min[node] + v;
      if (lo != hi) begin
        if (2 * node + 1 < NODES) tree_add[2 * node + 1] = tree_add[2 * node + 1] + v;
        if (2 * node + 2 < NODES) tree_add[2 * node + 2] = tree_add[2 * node + 2] + v;
      end
      return;
    end
    mid = lo + (hi - lo) / 2;
    walk_add(2 * node + 1, lo, mid, l, r, v);
    walk_add(2 * node + 2, mid + 1, hi, l, r, v);
    refresh(node);
  endfunction

  function automatic logic [31:0] walk_min(int node, int lo, int hi, int l, int r);
    int mid;
    if (node >= NODES || lo > r || hi < l) return rarmt_pkg::LARGEST;
    pass_down(node, lo, hi);
    if (l <= lo && hi <= r) return tree_min[node];
    mid = lo + (hi - lo) / 2;
    return rarmt_pkg::smin(walk_min(2 * node + 1, lo, mid, l, r),
                           walk_min(2 * node + 2, mid + 1, hi, l, r));
  endfunction

  function automatic void walk_load(int node, int lo, int hi, int idx, logic [31:0] v);
    int mid;
    if (node >= NODES) return;
    pass_down(node, lo, hi);
    if (lo == hi) begin
      tree_min[node] = v;
      return;
    end
    mid = lo + (hi - lo) / 2;
    if (idx <= mid) begin
      walk_load(2 * node + 1, lo, mid, idx, v);
      pass_down(2 * node + 2, mid + 1, hi);
    end else begin
      pass_down(2 * node + 1, lo, mid);
      walk_load(2 * node + 2, mid + 1, hi, idx, v);
    end
    refresh(node);
  endfunction

  function automatic rarmt_pkg::out_word_t tree_answer(rarmt_pkg::in_word_t w);
    rarmt_pkg::out_word_t o;
    int n;
    int l;
    int r;
    n = used_count();
    l = w.first_index;
    r = w.last_index;
    o.min_value = 0;
    o.range_error = 1'b0;
    if (w.func == rarmt_pkg::FUNC_LOAD) begin
      if (l >= n) o.range_error = 1'b1;
      else walk_load(0, 0, n - 1, l, w.operand_value);
    end else if (w.func == rarmt_pkg::FUNC_ADD || w.func == rarmt_pkg::FUNC_QUERY) begin
      if (l > r || r >= n) o.range_error = 1'b1;
      else if (w.func == rarmt_pkg::FUNC_ADD) walk_add(0, 0, n - 1, l, r, w.operand_value);
      else o.min_value = walk_min(0, 0, n - 1, l, r);
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h", what, got, want);
  endtask

  // Acceptance, configuration tracking and result checking.
  always @(posedge clk) begin
    cycles++;
    took = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        took = 1'b1;
        n_words++;
        if (in_data.func == rarmt_pkg::FUNC_QUERY) n_queries++;
        answer_q.push_back(tree_answer(in_data));
      end
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          report("unexpected word", out_data.min_value, 32'h0);
        end else begin
          rarmt_pkg::out_word_t e;
          e = answer_q.pop_front();
          if (e.range_error) n_rejects++;
          if (out_data.min_value !== e.min_value)
            report("min_value", out_data.min_value, e.min_value);
          if (out_data.range_error !== e.range_error)
            report("range_error", {31'd0, out_data.range_error}, {31'd0, e.range_error});
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Command driver.
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        idle_left <= $urandom_range(0, 3);
        start <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        in_data <= cmd_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_cmd(logic [1:0] f, int l, int r, logic [31:0] v);
    rarmt_pkg::in_word_t w;
    w.func = f;
    w.first_index = l[9:0];
    w.last_index = r[9:0];
    w.operand_value = v;
    cmd_q.push_back(w);
  endtask

  task automatic drain();
    wait (cmd_q.size() == 0 && !start && answer_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [rarmt_pkg::COUNT_W-1:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_cmds(int total);
    int n;
    int pick;
    int l;
    int r;
    n = used_count();
    repeat (total) begin
      pick = $urandom_range(0, 99);
      l = $urandom_range(0, n - 1);
      r = ($urandom_range(0, 1) == 0) ? l + $urandom_range(0, 7) : $urandom_range(l, n - 1);
      if (r > n - 1) r = n - 1;
      if (pick < 15) begin
        if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 1023);
        push_cmd(rarmt_pkg::FUNC_LOAD, l, $urandom_range(0, 1023), $urandom());
      end else if (pick < 50) begin
        push_cmd(rarmt_pkg::FUNC_ADD, l, r, ($urandom_range(0, 3) == 0) ? $urandom()
                                            : $urandom_range(0, 2000) - 1000);
      end else if (pick < 92) begin
        push_cmd(rarmt_pkg::FUNC_QUERY, l, r, $urandom());
      end else if (pick < 96) begin
        if (n < 1024 && $urandom_range(0, 1) == 0) r = $urandom_range(n, 1023);
        else if (l == r) r = l + 1;
        push_cmd(rarmt_pkg::FUNC_ADD + 2'($urandom_range(0, 1)), r, (n < 1024) ? r : l,
                 $urandom());
      end else begin
        push_cmd(rarmt_pkg::FUNC_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom());
      end
    end
  endtask

  task automatic phase(logic [rarmt_pkg::COUNT_W-1:0] c, int total);
    drain();
    write_count(c);
    random_cmds(total);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    n_words = 0;
    n_queries = 0;
    n_rejects = 0;
    idle_left = 0;
    calm = 1'b0;
    took = 1'b0;
    count_reg = rarmt_pkg::COUNT_RESET;
    for (int i = 0; i < NODES; i++) begin
      tree_min[i] = 0;
      tree_add[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_count(11'd1024);
    for (int i = 0; i < 1024; i++) push_cmd(rarmt_pkg::FUNC_LOAD, i, 1023 - i, $urandom());
    push_cmd(rarmt_pkg::FUNC_LOAD, 0, 0, 32'h8000_0000);
    push_cmd(rarmt_pkg::FUNC_LOAD, 1023, 0, 32'h7FFF_FFFF);
    push_cmd(rarmt_pkg::FUNC_QUERY, 0, 1023, 0);
    push_cmd(rarmt_pkg::FUNC_QUERY, 0, 0, 0);
    push_cmd(rarmt_pkg::FUNC_ADD, 0, 0, 32'hFFFF_FFFF);
    push_cmd(rarmt_pkg::FUNC_QUERY, 0, 0, 0);
    push_cmd(rarmt_pkg::FUNC_ADD, 512, 1023, 32'h7FFF_FFFF);
    push_cmd(rarmt_pkg::FUNC_QUERY, 1023, 1023, 0);
    push_cmd(rarmt_pkg::FUNC_QUERY, 400, 600, 0);
    push_cmd(rarmt_pkg::FUNC_ADD, 0, 1023, 32'h8000_0000);
    push_cmd(rarmt_pkg::FUNC_QUERY, 0, 1023, 0);
    push_cmd(rarmt_pkg::FUNC_QUERY, 5, 4, 0);
    push_cmd(rarmt_pkg::FUNC_ADD, 1023, 0, 1);
    push_cmd(rarmt_pkg::FUNC_NONE, 1023, 1023, 32'hFFFF_FFFF);
    random_cmds(300);

    drain();
    write_count(11'd10);
    push_cmd(rarmt_pkg::FUNC_LOAD, 10, 0, 5);
    push_cmd(rarmt_pkg::FUNC_QUERY, 3, 10, 0);
    push_cmd(rarmt_pkg::FUNC_ADD, 2, 1, 7);
    push_cmd(rarmt_pkg::FUNC_QUERY, 0, 9, 0);
    random_cmds(50);

    phase(11'd1, 60);
    phase(11'd0, 40);
    phase(11'd2, 80);
    phase(11'd1500, 150);
    phase(11'd7, 60);
    phase(11'd37, 80);
    phase(11'd2047, 150);
    drain();
    calm = 1'b1;
    write_count(11'd300);
    random_cmds(100);

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d command words, %0d range queries, %0d rejected words",
             n_words, n_queries, n_rejects);
    $display("element counts from 0 to 2047 were used; %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
